// File: design/hswr_pkg.sv
// ----------------------------------------------------------------------------
// hswr_pkg
// Shared types and constants for the height smoothstep weight ramp.
// ----------------------------------------------------------------------------
package hswr_pkg;

	localparam int OP_W     = 2;
	localparam int HEIGHT_W = 24;
	localparam int WEIGHT_W = 16;
	localparam int KNEE_W   = 16;
	localparam int CNT_W    = 17;

	// input opcodes
	localparam logic [OP_W-1:0] OP_START   = 2'd0;
	localparam logic [OP_W-1:0] OP_MEASURE = 2'd1;
	localparam logic [OP_W-1:0] OP_APPLY   = 2'd2;

	// knee fraction register, Q0.16
	localparam logic [KNEE_W-1:0] KNEE_LOW   = 16'd22938;
	localparam logic [KNEE_W-1:0] KNEE_HIGH  = 16'd42598;
	localparam logic [KNEE_W-1:0] KNEE_RESET = 16'd32768;

	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 24'sh7FFFFF;
	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 24'sh800000;

	// running counts stop here
	localparam logic [CNT_W-1:0] CNT_LIMIT = 17'd65536;

	// span * knee product and divider widths
	localparam int KPROD_W   = HEIGHT_W + KNEE_W;
	localparam int REM_W     = KPROD_W + 1;
	localparam int T_W       = 17;
	localparam int DIV_STEPS = T_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// smoothstep: 3 * 1.0 in Q0.16
	localparam int POLY_W = 18;
	localparam logic [POLY_W-1:0] SMOOTH_THREE = 18'd196608;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	typedef enum logic [1:0] {
		KIND_START,
		KIND_MEASURE,
		KIND_APPLY
	} kind_t;

	typedef struct packed {
		kind_t                       kind;
		logic signed [HEIGHT_W-1:0]  height;
		logic [WEIGHT_W-1:0]         weight;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPAN,
		ST_KNEE,
		ST_CMP,
		ST_DIV,
		ST_SQ,
		ST_CUBE,
		ST_SCALE,
		ST_EMIT
	} back_state_t;

endpackage

// File: design/hswr_if.sv
// ----------------------------------------------------------------------------
// hswr_req_if / hswr_rsp_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface hswr_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [hswr_pkg::OP_W-1:0]              opcode;
	logic signed [hswr_pkg::HEIGHT_W-1:0]   vertex_height;
	logic [hswr_pkg::WEIGHT_W-1:0]          weight_value;

	modport source (output valid, opcode, vertex_height, weight_value, input ready);
	modport sink (input valid, opcode, vertex_height, weight_value, output ready);
endinterface

interface hswr_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [hswr_pkg::WEIGHT_W-1:0]     new_weight;
	logic                              changed;
	logic                              activated;
	logic [hswr_pkg::CNT_W-1:0]        changed_total;
	logic [hswr_pkg::CNT_W-1:0]        activated_total;
	logic                              range_invalid;

	modport source (output valid, new_weight, changed, activated, changed_total,
		activated_total, range_invalid, input ready);
	modport sink (input valid, new_weight, changed, activated, changed_total,
		activated_total, range_invalid, output ready);
endinterface

// File: design/hswr_front.sv
// ----------------------------------------------------------------------------
// hswr_front
// Accepts input items, decodes the opcode and pushes work into the queue.
// ----------------------------------------------------------------------------
module hswr_front (
	hswr_req_if.sink             req,
	input  hswr_pkg::q_status_t  q_stat,
	output logic                 push,
	output hswr_pkg::item_t      item
);
	import hswr_pkg::*;

	logic known;

	assign req.ready = !q_stat.full;

	always_comb begin
		known       = 1'b1;
		item.kind   = KIND_START;
		item.height = req.vertex_height;
		item.weight = req.weight_value;
		unique case (req.opcode)
			OP_START:   item.kind = KIND_START;
			OP_MEASURE: item.kind = KIND_MEASURE;
			OP_APPLY:   item.kind = KIND_APPLY;
			default:    known = 1'b0;   // unused opcode is dropped
		endcase
	end

	assign push = req.valid && req.ready && known;

endmodule

// File: design/hswr_queue.sv
// ----------------------------------------------------------------------------
// hswr_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module hswr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  hswr_pkg::item_t      push_item,
	input  logic                 pop,
	output hswr_pkg::item_t      head,
	output hswr_pkg::q_status_t  q_stat
);
	import hswr_pkg::*;

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/hswr_back.sv
// ----------------------------------------------------------------------------
// hswr_back
// Executes queued items: statistics, knee test, serial divide, smoothstep.
// ----------------------------------------------------------------------------
module hswr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hswr_pkg::KNEE_W-1:0]   cfg_wdata,
	input  hswr_pkg::item_t               head,
	input  hswr_pkg::q_status_t           q_stat,
	output logic                          pop,
	hswr_rsp_if.source                    rsp
);
	import hswr_pkg::*;

	back_state_t state_q, state_d;
	logic load_out;

	// statistics and configuration
	logic [KNEE_W-1:0]           knee_q;
	logic signed [HEIGHT_W-1:0]  lo_q;
	logic signed [HEIGHT_W-1:0]  hi_q;
	logic [WEIGHT_W-1:0]         lw_q;
	logic [CNT_W-1:0]            chg_cnt_q;
	logic [CNT_W-1:0]            act_cnt_q;

	// apply datapath
	logic signed [HEIGHT_W-1:0]  h_q;
	logic [WEIGHT_W-1:0]         w_q;
	logic [HEIGHT_W-1:0]         span_q;
	logic signed [HEIGHT_W:0]    d_q;
	logic                        inval_q;
	logic [KPROD_W-1:0]          k_q;
	logic [REM_W-1:0]            r_q;
	logic [T_W-1:0]              quo_q;
	logic [DIV_CNT_W-1:0]        cnt_q;
	logic [T_W-1:0]              t_q;
	logic [2*T_W-1:0]            sq_q;
	logic [POLY_W-1:0]           poly_q;
	logic [T_W-1:0]              s_q;
	logic [WEIGHT_W-1:0]         nw_q;

	// output register
	logic                        out_valid_q;
	logic [WEIGHT_W-1:0]         out_nw_q;
	logic                        out_chg_q;
	logic                        out_act_q;
	logic [CNT_W-1:0]            out_chg_cnt_q;
	logic [CNT_W-1:0]            out_act_cnt_q;
	logic                        out_inval_q;

	logic signed [HEIGHT_W:0]    span;
	logic signed [HEIGHT_W:0]    d_full;
	logic                        range_bad;
	logic                        d_pos;
	logic                        above;
	logic                        div_ge;
	logic [REM_W-1:0]            div_rem;
	logic [T_W-1:0]              quo_next;
	logic [KPROD_W-1:0]          k_prod;
	logic [2*T_W-1:0]            sq_prod;
	logic [2*T_W+POLY_W-1:0]     cube_prod;
	logic [WEIGHT_W+T_W-1:0]     scale_prod;
	logic                        chg;
	logic                        act;
	logic [CNT_W-1:0]            chg_cnt_next;
	logic [CNT_W-1:0]            act_cnt_next;
	logic [KNEE_W-1:0]           knee_sat;

	assign span      = {hi_q[HEIGHT_W-1], hi_q} - {lo_q[HEIGHT_W-1], lo_q};
	assign d_full    = {h_q[HEIGHT_W-1], h_q} - {lo_q[HEIGHT_W-1], lo_q};
	assign range_bad = (span <= 0) || (lw_q == '0);

	// d > 0 and d*65536 > span*knee
	assign d_pos = !d_q[HEIGHT_W] && (d_q != '0);
	assign above = d_pos && ({d_q[HEIGHT_W-1:0], 16'h0000} > k_q);

	// restoring divide, one quotient bit per cycle; remainder stays below k
	assign div_ge   = (r_q >= {1'b0, k_q});
	assign div_rem  = div_ge ? (r_q - {1'b0, k_q}) : r_q;
	assign quo_next = {quo_q[T_W-2:0], div_ge};

	assign k_prod     = span_q * knee_q;
	assign sq_prod    = t_q * t_q;
	assign cube_prod  = sq_q * poly_q;
	assign scale_prod = lw_q * s_q;

	assign chg = (nw_q != w_q);
	assign act = (w_q == '0) && (nw_q != '0);
	assign chg_cnt_next = (chg && chg_cnt_q < CNT_LIMIT) ? chg_cnt_q + 1'b1 : chg_cnt_q;
	assign act_cnt_next = (act && act_cnt_q < CNT_LIMIT) ? act_cnt_q + 1'b1 : act_cnt_q;

	assign knee_sat = (cfg_wdata < KNEE_LOW)  ? KNEE_LOW :
	                  (cfg_wdata > KNEE_HIGH) ? KNEE_HIGH : cfg_wdata;

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					pop = 1'b1;
					if (head.kind == KIND_APPLY) begin
						state_d = ST_SPAN;
					end
				end
			end
			ST_SPAN:  state_d = range_bad ? ST_EMIT : ST_KNEE;
			ST_KNEE:  state_d = ST_CMP;
			ST_CMP: begin
				if (above) begin
					state_d = ST_EMIT;
				end else if (d_pos) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_SQ;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_SQ;
				end
			end
			ST_SQ:    state_d = ST_CUBE;
			ST_CUBE:  state_d = ST_SCALE;
			ST_SCALE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// statistics, counts, knee and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knee_q      <= KNEE_RESET;
			lo_q        <= HEIGHT_MAX;
			hi_q        <= HEIGHT_MIN;
			lw_q        <= '0;
			chg_cnt_q   <= '0;
			act_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				knee_q <= knee_sat;
			end
			if (pop) begin
				case (head.kind)
					KIND_START: begin
						lo_q      <= HEIGHT_MAX;
						hi_q      <= HEIGHT_MIN;
						lw_q      <= '0;
						chg_cnt_q <= '0;
						act_cnt_q <= '0;
					end
					KIND_MEASURE: begin
						if (head.height < lo_q) begin
							lo_q <= head.height;
						end
						if (head.height > hi_q) begin
							hi_q <= head.height;
						end
						if (head.weight > lw_q) begin
							lw_q <= head.weight;
						end
					end
					default: ;
				endcase
			end
			if (load_out) begin
				chg_cnt_q   <= chg_cnt_next;
				act_cnt_q   <= act_cnt_next;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// apply datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				h_q <= head.height;
				w_q <= head.weight;
			end
			ST_SPAN: begin
				span_q  <= span[HEIGHT_W-1:0];
				d_q     <= d_full;
				inval_q <= range_bad;
				nw_q    <= w_q;
			end
			ST_KNEE: k_q <= k_prod;
			ST_CMP: begin
				r_q   <= {1'b0, d_q[HEIGHT_W-1:0], 16'h0000};
				quo_q <= '0;
				cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
				t_q   <= '0;   // height at or below lowest
			end
			ST_DIV: begin
				quo_q <= quo_next;
				r_q   <= {div_rem[REM_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					t_q <= quo_next;
				end
			end
			ST_SQ: begin
				sq_q   <= sq_prod;
				poly_q <= SMOOTH_THREE - {t_q, 1'b0};
			end
			ST_CUBE:  s_q  <= cube_prod[2*WEIGHT_W+T_W-1:2*WEIGHT_W];
			ST_SCALE: nw_q <= scale_prod[2*WEIGHT_W-1:WEIGHT_W];
			default: ;
		endcase
		if (load_out) begin
			out_nw_q      <= nw_q;
			out_chg_q     <= chg;
			out_act_q     <= act;
			out_chg_cnt_q <= chg_cnt_next;
			out_act_cnt_q <= act_cnt_next;
			out_inval_q   <= inval_q;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.new_weight      = out_nw_q;
	assign rsp.changed         = out_chg_q;
	assign rsp.activated       = out_act_q;
	assign rsp.changed_total   = out_chg_cnt_q;
	assign rsp.activated_total = out_act_cnt_q;
	assign rsp.range_invalid   = out_inval_q;

endmodule

// File: design/height_smoothstep_weight_ramp_top.sv
// Start and measure items are popped in the back end's idle state, one per cycle while
// no apply item is in progress. An apply item runs span, knee, compare, the 17-step
// divider, square, cube, scale and emit states, skipping those its case does not need.
// The front takes items into a 2-entry queue while the back end is busy.
// Reset (arst_n low) empties the queue, drops any result and restores the statistics,
// counts and a knee fraction of 0.5.
// ----------------------------------------------------------------------------
// height_smoothstep_weight_ramp_top
// Height-driven smoothstep remap of vertex weights, front/queue/back split.
// ----------------------------------------------------------------------------
module height_smoothstep_weight_ramp_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hswr_pkg::KNEE_W-1:0]   cfg_wdata,
	hswr_req_if.sink                      req,
	hswr_rsp_if.source                    rsp
);
	import hswr_pkg::*;

	logic       push;
	logic       pop;
	item_t      push_item;
	item_t      head;
	q_status_t  q_stat;

	hswr_front u_front (
		.req    (req),
		.q_stat (q_stat),
		.push   (push),
		.item   (push_item)
	);

	hswr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	hswr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("item pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.changed_total <= CNT_LIMIT) && (rsp.activated_total <= CNT_LIMIT))
		else $error("running count above limit");

	a_invalid_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.range_invalid |-> !rsp.changed && !rsp.activated)
		else $error("invalid range result flagged as changed");

	a_activated_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.activated |-> rsp.changed && (rsp.activated_total != '0))
		else $error("activated result without change or count");
`endif

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for height_smoothstep_weight_ramp_top. Directed items
// cover the edge heights, weights, opcodes and invalid ranges. Random measure
// and apply sequences then run under several knee settings, with random gaps
// on both channels and one long result stall. A scoreboard predicts each apply
// result and checks every field in order.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [hswr_pkg::WEIGHT_W-1:0] new_weight;
	logic                          changed;
	logic                          activated;
	logic [hswr_pkg::CNT_W-1:0]    changed_total;
	logic [hswr_pkg::CNT_W-1:0]    activated_total;
	logic                          range_invalid;
} ramp_result_t;

class weight_ramp_scoreboard;
	logic [hswr_pkg::KNEE_W-1:0]          knee_frac;
	logic signed [hswr_pkg::HEIGHT_W-1:0] low_h;
	logic signed [hswr_pkg::HEIGHT_W-1:0] high_h;
	logic [hswr_pkg::WEIGHT_W-1:0]        peak_w;
	logic [hswr_pkg::CNT_W-1:0]           chg_cnt;
	logic [hswr_pkg::CNT_W-1:0]           act_cnt;
	ramp_result_t                         expected_weights[$];
	int                                   mismatch_count;

	function new();
		knee_frac = hswr_pkg::KNEE_RESET;
		mismatch_count = 0;
		clear_stats();
	endfunction

	function void clear_stats();
		low_h = hswr_pkg::HEIGHT_MAX;
		high_h = hswr_pkg::HEIGHT_MIN;
		peak_w = '0;
		chg_cnt = '0;
		act_cnt = '0;
	endfunction

	function void set_knee(logic [hswr_pkg::KNEE_W-1:0] value);
		if (value < hswr_pkg::KNEE_LOW)
			knee_frac = hswr_pkg::KNEE_LOW;
		else if (value > hswr_pkg::KNEE_HIGH)
			knee_frac = hswr_pkg::KNEE_HIGH;
		else
			knee_frac = value;
	endfunction

	function int pending();
		return expected_weights.size();
	endfunction

	// one accepted input item
	function void note_vertex_item(logic [hswr_pkg::OP_W-1:0] op,
			logic signed [hswr_pkg::HEIGHT_W-1:0] h, logic [hswr_pkg::WEIGHT_W-1:0] w);
		longint       span;
		longint       rel_h;
		bit [63:0]    udist;
		bit [63:0]    kprod;
		bit [63:0]    t;
		bit [63:0]    s;
		bit [63:0]    desired;
		bit           above;
		ramp_result_t r;
		case (op)
			hswr_pkg::OP_START: begin
				clear_stats();
				return;
			end
			hswr_pkg::OP_MEASURE: begin
				if (h < low_h)
					low_h = h;
				if (h > high_h)
					high_h = h;
				if (w > peak_w)
					peak_w = w;
				return;
			end
			hswr_pkg::OP_APPLY: ;
			default: return;
		endcase
		r.new_weight = w;
		r.changed = 1'b0;
		r.activated = 1'b0;
		r.range_invalid = 1'b0;
		span = longint'(high_h) - longint'(low_h);
		if (span <= 0 || peak_w == 0) begin
			r.range_invalid = 1'b1;
		end else begin
			kprod = span;
			kprod = kprod * knee_frac;
			rel_h = longint'(h) - longint'(low_h);
			udist = rel_h;
			above = (rel_h > 0) && ((udist << 16) > kprod);
			if (!above) begin
				t = 0;
				if (rel_h > 0) begin
					t = (udist << 32) / kprod;
					if (t > 64'd65536)
						t = 64'd65536;
				end
				s = (t * t * (64'(hswr_pkg::SMOOTH_THREE) - 2 * t)) >> 32;
				desired = (64'(peak_w) * s) >> 16;
				if (desired > 64'hFFFF)
					desired = 64'hFFFF;
				r.new_weight = desired[hswr_pkg::WEIGHT_W-1:0];
				if (r.new_weight != w) begin
					r.changed = 1'b1;
					if (w == 0 && r.new_weight != 0) begin
						r.activated = 1'b1;
						if (act_cnt < hswr_pkg::CNT_LIMIT)
							act_cnt = act_cnt + 1'b1;
					end
					if (chg_cnt < hswr_pkg::CNT_LIMIT)
						chg_cnt = chg_cnt + 1'b1;
				end
			end
		end
		r.changed_total = chg_cnt;
		r.activated_total = act_cnt;
		expected_weights.push_back(r);
	endfunction

	function void check_weight_result(ramp_result_t got);
		ramp_result_t want;
		if (expected_weights.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("error: result with nothing expected: weight %h chg %b act %b",
					got.new_weight, got.changed, got.activated);
			return;
		end
		want = expected_weights.pop_front();
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("mismatch: expected w %h chg %b act %b ctot %0d atot %0d inv %b",
					want.new_weight, want.changed, want.activated, want.changed_total,
					want.activated_total, want.range_invalid);
				$display("          actual   w %h chg %b act %b ctot %0d atot %0d inv %b",
					got.new_weight, got.changed, got.activated, got.changed_total,
					got.activated_total, got.range_invalid);
			end
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hswr_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int GAP_MAX      = 17;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int BLOCK_ITEMS  = 195;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [KNEE_W-1:0]  cfg_wdata;

	hswr_req_if req_ch();
	hswr_rsp_if rsp_ch();

	height_smoothstep_weight_ramp_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	weight_ramp_scoreboard ramp_sb;
	int                    items_sent;
	bit                    send_gaps_on;
	bit                    recv_gaps_on;
	bit                    hold_request;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("status: fail");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int           stall;
		ramp_result_t got;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = recv_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
			if (hold_request) begin
				stall = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (stall > 0) begin
				@(negedge clk) rsp_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (rsp_ch.valid !== 1'b1);
			got.new_weight = rsp_ch.new_weight;
			got.changed = rsp_ch.changed;
			got.activated = rsp_ch.activated;
			got.changed_total = rsp_ch.changed_total;
			got.activated_total = rsp_ch.activated_total;
			got.range_invalid = rsp_ch.range_invalid;
			ramp_sb.check_weight_result(got);
		end
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic signed [HEIGHT_W-1:0] h,
			input logic [WEIGHT_W-1:0] w);
		int gap;
		gap = send_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
		if (gap > 0) begin
			@(negedge clk) req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.vertex_height <= h;
		req_ch.weight_value <= w;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		ramp_sb.note_vertex_item(op, h, w);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk) req_ch.valid <= 1'b0;
		while (ramp_sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_knee(input logic [KNEE_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk) cfg_we <= 1'b0;
		ramp_sb.set_knee(value);
	endtask

	function automatic logic signed [HEIGHT_W-1:0] clip_height(int hv);
		if (hv > int'(HEIGHT_MAX))
			return HEIGHT_MAX;
		if (hv < int'(HEIGHT_MIN))
			return HEIGHT_MIN;
		return hv[HEIGHT_W-1:0];
	endfunction

	// usually a start, a few measures, then a run of applies around the measured range
	task automatic run_sequence();
		int                          base;
		int                          width;
		int                          lo_seen;
		int                          hi_seen;
		int                          hv;
		int                          n_meas;
		int                          n_apply;
		logic signed [HEIGHT_W-1:0]  hs;
		logic [WEIGHT_W-1:0]         wv;
		if ($urandom_range(0, 7) != 0)
			send_item(OP_START, HEIGHT_W'($urandom), WEIGHT_W'($urandom));
		hs = HEIGHT_W'($urandom);
		base = int'(hs);
		case ($urandom_range(0, 3))
			0: width = $urandom_range(0, 3);
			1: width = $urandom_range(1, 255);
			2: width = $urandom_range(256, 65535);
			default: width = $urandom_range(0, 24'hFFFFFF);
		endcase
		lo_seen = int'(HEIGHT_MAX);
		hi_seen = int'(HEIGHT_MIN);
		n_meas = $urandom_range(1, 6);
		repeat (n_meas) begin
			hs = clip_height(base + int'($urandom_range(0, width)));
			hv = int'(hs);
			wv = ($urandom_range(0, 5) == 0) ? '0 : WEIGHT_W'($urandom);
			send_item(OP_MEASURE, hs, wv);
			if (hv < lo_seen)
				lo_seen = hv;
			if (hv > hi_seen)
				hi_seen = hv;
		end
		n_apply = $urandom_range(3, 14);
		repeat (n_apply) begin
			case ($urandom_range(0, 5))
				0: hv = lo_seen;
				1: hv = hi_seen;
				2, 3: hv = lo_seen + int'($urandom_range(0, hi_seen - lo_seen));
				4: hv = lo_seen - int'($urandom_range(1, 64));
				default: begin
					hs = HEIGHT_W'($urandom);
					hv = int'(hs);
				end
			endcase
			case ($urandom_range(0, 3))
				0: wv = '0;
				1: wv = WEIGHT_W'($urandom_range(0, 255));
				default: wv = WEIGHT_W'($urandom);
			endcase
			// broken sequences: stray measures and unused opcodes
			case ($urandom_range(0, 19))
				0: send_item(OP_UNUSED, HEIGHT_W'($urandom), WEIGHT_W'($urandom));
				1: send_item(OP_MEASURE, HEIGHT_W'($urandom), WEIGHT_W'($urandom));
				default: ;
			endcase
			send_item(OP_APPLY, clip_height(hv), wv);
		end
	endtask

	task automatic run_random_block(input int target);
		int stop_at;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 85)
				run_sequence();
			else
				send_item(OP_W'($urandom_range(0, 3)), HEIGHT_W'($urandom),
					WEIGHT_W'($urandom));
		end
	endtask

	initial begin
		logic [KNEE_W-1:0] knee_plan[6];
		ramp_sb = new();
		items_sent = 0;
		send_gaps_on = 1'b1;
		recv_gaps_on = 1'b1;
		hold_request = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_START;
		req_ch.vertex_height = '0;
		req_ch.weight_value = '0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// nothing measured yet: range invalid
		send_item(OP_APPLY, 24'sd0, 16'h0100);
		send_item(OP_UNUSED, HEIGHT_MAX, 16'hFFFF);
		// single height, zero weight, then zero largest weight with a span
		send_item(OP_MEASURE, 24'sd0, 16'h0000);
		send_item(OP_APPLY, 24'sd0, 16'h0010);
		send_item(OP_MEASURE, 24'sd65536, 16'h0000);
		send_item(OP_APPLY, 24'sd100, 16'h0010);
		send_item(OP_MEASURE, 24'sd100, 16'h0200);
		// below lowest, at the knee, just above it, mid ramp
		send_item(OP_APPLY, -24'sd5, 16'h0000);
		send_item(OP_APPLY, -24'sd5, 16'h0080);
		send_item(OP_APPLY, 24'sd32768, 16'h0000);
		send_item(OP_APPLY, 24'sd32768, 16'h0200);
		send_item(OP_APPLY, 24'sd32769, 16'h0033);
		send_item(OP_APPLY, 24'sd16384, 16'h0000);
		send_item(OP_APPLY, 24'sd65536, 16'hFFFF);
		// full height range
		send_item(OP_START, HEIGHT_MAX, 16'hFFFF);
		send_item(OP_MEASURE, HEIGHT_MIN, 16'hFFFF);
		send_item(OP_MEASURE, HEIGHT_MAX, 16'h1234);
		send_item(OP_APPLY, HEIGHT_MIN, 16'h0000);
		send_item(OP_APPLY, HEIGHT_MAX, 16'hFFFF);
		send_item(OP_APPLY, 24'sd0, 16'h0000);
		send_item(OP_APPLY, -24'sd1, 16'hAAAA);
		send_item(OP_APPLY, 24'sh555555, 16'h5555);
		send_item(OP_UNUSED, HEIGHT_MIN, 16'h0000);

		knee_plan[0] = 16'h0000;
		knee_plan[1] = 16'hFFFF;
		knee_plan[2] = KNEE_LOW;
		knee_plan[3] = KNEE_HIGH;
		knee_plan[4] = KNEE_W'($urandom_range(KNEE_LOW, KNEE_HIGH));
		knee_plan[5] = KNEE_W'($urandom);
		for (int i = 0; i < 6; i++) begin
			wait_idle();
			write_knee(knee_plan[i]);
			send_gaps_on = (i != 2) && (i != 3);
			recv_gaps_on = (i != 2);
			// input backs up behind a stalled result channel
			if (i == 3)
				hold_request = 1'b1;
			run_random_block(BLOCK_ITEMS);
		end

		wait_idle();
		if (ramp_sb.mismatch_count == 0 && ramp_sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
